[rtl/core/rbst_pkg.sv]
package rbst_pkg;

	localparam int unsigned NumAxes  = 3;
	localparam int unsigned CoordW   = 32;
	localparam int unsigned DistW    = 30;
	localparam int unsigned CfgIdxW  = 3;
	// numerator |face - origin| << 16 fits in 49 bits
	localparam int unsigned NumW     = 49;
	localparam int unsigned DenW     = 32;
	localparam logic [DistW-1:0] TInf = 30'd655360000;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CoordW-1:0] origin_x;
		logic signed [CoordW-1:0] origin_y;
		logic signed [CoordW-1:0] origin_z;
		logic signed [CoordW-1:0] dir_x;
		logic signed [CoordW-1:0] dir_y;
		logic signed [CoordW-1:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic             hit;
		logic [DistW-1:0] t_enter;
		logic [DistW-1:0] t_exit;
	} result_t;

	// per-lane findings handed to the merge stage
	typedef struct packed {
		logic             miss;
		logic [DistW-1:0] t_a;
		logic [DistW-1:0] t_b;
	} lane_res_t;

endpackage

[rtl/core/rbst_div.sv]
// Pipelined restoring divider: one quotient bit per stage, NumW stages.
// Quotient saturates to TInf at the output. A zero flag bypasses the divide.
module rbst_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [rbst_pkg::NumW-1:0]          num,
	input  logic [rbst_pkg::DenW-1:0]          den,
	input  logic                               zero,
	output logic [rbst_pkg::DistW-1:0]         quo
);
	localparam int unsigned N = rbst_pkg::NumW;
	localparam int unsigned D = rbst_pkg::DenW;

	logic [N-1:0] num_s [0:N];
	logic [N-1:0] q_s   [0:N];
	logic [D:0]   rem_s [0:N];
	logic [D-1:0] den_s [0:N];
	logic         zero_s[0:N];

	assign num_s[0]  = num;
	assign q_s[0]    = '0;
	assign rem_s[0]  = '0;
	assign den_s[0]  = den;
	assign zero_s[0] = zero;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [D+1:0] trial;
		logic [D:0]   shifted;
		assign shifted = {rem_s[k][D-1:0], num_s[k][N-1-k]};
		assign trial   = {1'b0, shifted} - {2'b00, den_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1]  <= num_s[k];
				den_s[k+1]  <= den_s[k];
				zero_s[k+1] <= zero_s[k];
				if (!trial[D+1]) begin
					rem_s[k+1] <= trial[D:0];
					q_s[k+1]   <= q_s[k] | (N'(1) << (N-1-k));
				end else begin
					rem_s[k+1] <= shifted;
					q_s[k+1]   <= q_s[k];
				end
			end
		end
	end

	always_comb begin
		if (zero_s[N])
			quo = '0;
		else if (q_s[N] > N'(rbst_pkg::TInf))
			quo = rbst_pkg::TInf;
		else
			quo = q_s[N][rbst_pkg::DistW-1:0];
	end

	logic unused_rst;
	assign unused_rst = arst_n;
endmodule

[rtl/core/rbst_lane.sv]
// One axis: face differences, two dividers, zero-direction check.
module rbst_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic signed [rbst_pkg::CoordW-1:0]    origin,
	input  logic signed [rbst_pkg::CoordW-1:0]    dir,
	input  logic signed [rbst_pkg::CoordW-1:0]    lo,
	input  logic signed [rbst_pkg::CoordW-1:0]    hi,
	output rbst_pkg::lane_res_t                   res
);
	localparam int unsigned W = rbst_pkg::CoordW;
	localparam int unsigned N = rbst_pkg::NumW;
	localparam int unsigned Depth = rbst_pkg::NumW;

	logic signed [W:0] diff_lo, diff_hi, near_d, far_d;
	logic [W-1:0]      adir;
	logic              dzero, dneg, zmiss;
	logic              near_z, far_z;

	assign dzero   = (dir == '0);
	assign dneg    = dir[W-1];
	assign diff_lo = {lo[W-1], lo} - {origin[W-1], origin};
	assign diff_hi = {hi[W-1], hi} - {origin[W-1], origin};
	assign near_d  = dneg ? diff_hi : diff_lo;
	assign far_d   = dneg ? diff_lo : diff_hi;
	assign adir    = dneg ? W'(-{1'b1, dir}) : dir;
	assign zmiss   = dzero && ((origin <= lo) || (hi <= origin));

	// distance zero when dir is zero, diff is zero or its sign differs from dir
	assign near_z  = dzero || (near_d == '0) || (near_d[W] != dneg);
	assign far_z   = dzero || (far_d == '0) || (far_d[W] != dneg);

	logic [W:0] near_m, far_m;
	assign near_m = near_d[W] ? -near_d : near_d;
	assign far_m  = far_d[W] ? -far_d : far_d;

	logic [rbst_pkg::DistW-1:0] qa, qb;

	rbst_div u_div_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num({near_m[N-17:0], 16'h0}), .den(adir), .zero(near_z), .quo(qa)
	);
	rbst_div u_div_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num({far_m[N-17:0], 16'h0}), .den(adir), .zero(far_z), .quo(qb)
	);

	// carry zero-direction info alongside the dividers
	logic zd_s [0:Depth-1];
	logic zm_s [0:Depth-1];
	always_ff @(posedge clk) begin
		if (en) begin
			zd_s[0] <= dzero;
			zm_s[0] <= zmiss;
			for (int k = 1; k < Depth; k++) begin
				zd_s[k] <= zd_s[k-1];
				zm_s[k] <= zm_s[k-1];
			end
		end
	end

	assign res.miss = zm_s[Depth-1];
	assign res.t_a  = qa;
	assign res.t_b  = zd_s[Depth-1] ? rbst_pkg::TInf : qb;
endmodule

[rtl/core/rbst_merge.sv]
// Max of entries, min of exits, hit decision.
module rbst_merge (
	input  rbst_pkg::lane_res_t lx,
	input  rbst_pkg::lane_res_t ly,
	input  rbst_pkg::lane_res_t lz,
	output rbst_pkg::result_t   res
);
	logic [rbst_pkg::DistW-1:0] ent, ext, e1, x1;
	logic                       miss;

	always_comb begin
		e1   = (lx.t_a > ly.t_a) ? lx.t_a : ly.t_a;
		ent  = (e1 > lz.t_a) ? e1 : lz.t_a;
		x1   = (lx.t_b < ly.t_b) ? lx.t_b : ly.t_b;
		ext  = (x1 < lz.t_b) ? x1 : lz.t_b;
		miss = lx.miss || ly.miss || lz.miss || (ext <= ent);
		res.hit     = !miss;
		res.t_enter = miss ? '0 : ent;
		res.t_exit  = miss ? '0 : ext;
	end
endmodule

[rtl/core/ray_box_slab_test_top.sv]
// Channel  | Handshake          | Payload
// in       | in_valid/in_ready  | in_data  (rbst_pkg::ray_t)
// out      | out_valid/out_ready| out_data (rbst_pkg::result_t)
// cfg      | cfg_we             | cfg_idx, cfg_wdata
// One ray per cycle while the output is not stalled. The path is 49 divider stages (one quotient
// bit each) and one output register.
// The pipeline advances when the output register is empty or being taken;
// a stall holds every stage. Reset clears valid bits and box registers.
module ray_box_slab_test_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rbst_pkg::ray_t                    in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rbst_pkg::result_t                 out_data,
	input  logic                              cfg_we,
	input  logic [rbst_pkg::CfgIdxW-1:0]      cfg_idx,
	input  logic [rbst_pkg::CoordW-1:0]       cfg_wdata
);
	localparam int unsigned Depth = rbst_pkg::NumW + 1;

	logic signed [rbst_pkg::CoordW-1:0] lo_q [0:rbst_pkg::NumAxes-1];
	logic signed [rbst_pkg::CoordW-1:0] hi_q [0:rbst_pkg::NumAxes-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rbst_pkg::NumAxes; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (rbst_pkg::cfg_reg_t'(cfg_idx))
				rbst_pkg::REG_MIN_X: lo_q[0] <= cfg_wdata;
				rbst_pkg::REG_MIN_Y: lo_q[1] <= cfg_wdata;
				rbst_pkg::REG_MIN_Z: lo_q[2] <= cfg_wdata;
				rbst_pkg::REG_MAX_X: hi_q[0] <= cfg_wdata;
				rbst_pkg::REG_MAX_Y: hi_q[1] <= cfg_wdata;
				rbst_pkg::REG_MAX_Z: hi_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic en;
	logic [Depth-2:0] vld_q;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Depth-3:0], in_valid};
	end

	rbst_pkg::lane_res_t lr_x, lr_y, lr_z;

	rbst_lane u_lane_x (.clk(clk), .arst_n(arst_n), .en(en),
		.origin(in_data.origin_x), .dir(in_data.dir_x),
		.lo(lo_q[0]), .hi(hi_q[0]), .res(lr_x));
	rbst_lane u_lane_y (.clk(clk), .arst_n(arst_n), .en(en),
		.origin(in_data.origin_y), .dir(in_data.dir_y),
		.lo(lo_q[1]), .hi(hi_q[1]), .res(lr_y));
	rbst_lane u_lane_z (.clk(clk), .arst_n(arst_n), .en(en),
		.origin(in_data.origin_z), .dir(in_data.dir_z),
		.lo(lo_q[2]), .hi(hi_q[2]), .res(lr_z));

	rbst_pkg::result_t merged;
	rbst_merge u_merge (.lx(lr_x), .ly(lr_y), .lz(lr_z), .res(merged));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_q[Depth-2];
	end

	always_ff @(posedge clk) begin
		if (en) out_data <= merged;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready mismatch");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.t_enter == '0 && out_data.t_exit == '0)
		else $error("miss with nonzero distance");
	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.t_exit > out_data.t_enter)
		else $error("hit with exit not after entry");
endmodule
